// ----- hdl/rqca_pkg.sv -----
// shared types, widths and codes of the retransmit queue
package rqca_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int MODE_W      = 3;
	localparam int HANDLE_W    = 16;
	localparam int ACK_W       = 31;
	localparam int TIME_W      = 32;
	localparam int TMO_W       = 16;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd5;

	// input mode codes
	localparam logic [MODE_W-1:0] MODE_ENQ        = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DEQ        = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ACK        = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RESEND_EXP = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RESEND_ALL = 3'd4;

	// result kind codes
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_RESEND = 1'b1;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ENQ,
		OP_DEQ,
		OP_ACK,
		OP_RESEND
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic                resend_all;
		logic [HANDLE_W-1:0] handle;
		logic [ACK_W-1:0]    mack;
		logic [ACK_W-1:0]    ackv;
		logic [TIME_W-1:0]   now;
	} cmd_t;

	typedef struct packed {
		logic                kind;
		logic [HANDLE_W-1:0] handle;
		logic                is_empty;
		logic [CNT_W-1:0]    count;
		logic                overflow;
		logic                last;
	} result_t;

endpackage

// ----- hdl/rqca_ram.sv -----
// generic single write port ram with registered read
module rqca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/rqca_front.sv -----
// front end: accepts input beats, decodes the mode and queues commands
module rqca_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [rqca_pkg::MODE_W-1:0]    mode,
	input  logic [rqca_pkg::HANDLE_W-1:0]  message_handle,
	input  logic [rqca_pkg::ACK_W-1:0]     message_ack,
	input  logic [rqca_pkg::ACK_W-1:0]     ack_value,
	input  logic [rqca_pkg::TIME_W-1:0]    now_sec,
	output logic                           cmd_valid,
	output rqca_pkg::cmd_t                 cmd,
	input  logic                           cmd_take
);
	import rqca_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		dec            = '0;
		dec.handle     = message_handle;
		dec.mack       = message_ack;
		dec.ackv       = ack_value;
		dec.now        = now_sec;
		dec.resend_all = 1'b0;
		unique case (mode)
			MODE_ENQ:        dec.op = OP_ENQ;
			MODE_DEQ:        dec.op = OP_DEQ;
			MODE_ACK:        dec.op = OP_ACK;
			MODE_RESEND_EXP: dec.op = OP_RESEND;
			MODE_RESEND_ALL: begin
				dec.op         = OP_RESEND;
				dec.resend_all = 1'b1;
			end
			default:         dec.op = OP_NOP;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ----- hdl/rqca_back.sv -----
// back end: owns the entry memories and pointers and sequences each command
module rqca_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  rqca_pkg::cmd_t                cmd,
	output logic                          cmd_take,
	input  logic [rqca_pkg::TMO_W-1:0]    timeout_sec,
	output logic                          res_valid,
	output rqca_pkg::result_t             res,
	input  logic                          res_ready
);
	import rqca_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_DEQ_RD   = 9'b000000010,
		ST_DEQ_OUT  = 9'b000000100,
		ST_ACK_RD   = 9'b000001000,
		ST_ACK_CHK  = 9'b000010000,
		ST_SCAN_RD  = 9'b000100000,
		ST_SCAN_CHK = 9'b001000000,
		ST_STAT_RD  = 9'b010000000,
		ST_STAT_OUT = 9'b100000000
	} state_t;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	state_t            state_q, state_d;
	cmd_t              cmd_q, cmd_d;
	logic [PTR_W-1:0]  head_q, head_d;
	logic [PTR_W-1:0]  tail_q, tail_d;
	logic [CNT_W-1:0]  occ_q, occ_d;
	logic [PTR_W-1:0]  scan_ptr_q, scan_ptr_d;
	logic [CNT_W-1:0]  scan_left_q, scan_left_d;
	logic              ovf_q, ovf_d;

	logic                entry_we;
	logic                stamp_we;
	logic [PTR_W-1:0]    waddr;
	logic [TIME_W-1:0]   stamp_wdata;
	logic                re;
	logic [PTR_W-1:0]    raddr;
	logic [HANDLE_W-1:0] handle_rd;
	logic [ACK_W-1:0]    ack_rd;
	logic [TIME_W-1:0]   stamp_rd;
	logic [TIME_W-1:0]   age;
	logic                send;

	rqca_ram #(.WIDTH(HANDLE_W), .DEPTH(QUEUE_DEPTH)) u_handles (
		.clk   (clk),
		.we    (entry_we),
		.waddr (waddr),
		.wdata (cmd.handle),
		.re    (re),
		.raddr (raddr),
		.rdata (handle_rd)
	);

	rqca_ram #(.WIDTH(ACK_W), .DEPTH(QUEUE_DEPTH)) u_acks (
		.clk   (clk),
		.we    (entry_we),
		.waddr (waddr),
		.wdata (cmd.mack),
		.re    (re),
		.raddr (raddr),
		.rdata (ack_rd)
	);

	rqca_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_DEPTH)) u_stamps (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (waddr),
		.wdata (stamp_wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (stamp_rd)
	);

	// wrapping age against the registered stamp
	assign age  = cmd_q.now - stamp_rd;
	assign send = cmd_q.resend_all || (age > {{(TIME_W-TMO_W){1'b0}}, timeout_sec});

	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		head_d      = head_q;
		tail_d      = tail_q;
		occ_d       = occ_q;
		scan_ptr_d  = scan_ptr_q;
		scan_left_d = scan_left_q;
		ovf_d       = ovf_q;
		cmd_take    = 1'b0;
		entry_we    = 1'b0;
		stamp_we    = 1'b0;
		waddr       = tail_q;
		stamp_wdata = cmd.now;
		re          = 1'b0;
		raddr       = head_q;
		res_valid   = 1'b0;
		res         = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					cmd_d    = cmd;
					ovf_d    = 1'b0;
					unique case (cmd.op)
						OP_ENQ: begin
							if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
								ovf_d = 1'b1;
							end else begin
								entry_we = 1'b1;
								stamp_we = 1'b1;
								tail_d   = next_slot(tail_q);
								occ_d    = occ_q + 1'b1;
							end
							state_d = ST_STAT_RD;
						end
						OP_DEQ:  state_d = ST_DEQ_RD;
						OP_ACK:  state_d = ST_ACK_RD;
						OP_RESEND: begin
							scan_ptr_d  = head_q;
							scan_left_d = occ_q;
							state_d     = ST_SCAN_RD;
						end
						default: state_d = ST_STAT_RD;
					endcase
				end
			end
			ST_DEQ_RD: begin
				re      = 1'b1;
				state_d = ST_DEQ_OUT;
			end
			ST_DEQ_OUT: begin
				res_valid = 1'b1;
				res.kind  = KIND_STATUS;
				res.last  = 1'b1;
				if (occ_q == '0) begin
					res.is_empty = 1'b1;
				end else begin
					res.handle = handle_rd;
					res.count  = occ_q - 1'b1;
				end
				if (res_ready) begin
					if (occ_q != '0) begin
						head_d = next_slot(head_q);
						occ_d  = occ_q - 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_ACK_RD: begin
				if (occ_q == '0) begin
					state_d = ST_STAT_RD;
				end else begin
					re      = 1'b1;
					state_d = ST_ACK_CHK;
				end
			end
			ST_ACK_CHK: begin
				// drop the head while its number is below the cumulative ack
				if (ack_rd < cmd_q.ackv) begin
					head_d  = next_slot(head_q);
					occ_d   = occ_q - 1'b1;
					state_d = ST_ACK_RD;
				end else begin
					state_d = ST_STAT_RD;
				end
			end
			ST_SCAN_RD: begin
				if (scan_left_q == '0) begin
					state_d = ST_STAT_RD;
				end else begin
					re      = 1'b1;
					raddr   = scan_ptr_q;
					state_d = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				if (!send) begin
					scan_ptr_d  = next_slot(scan_ptr_q);
					scan_left_d = scan_left_q - 1'b1;
					state_d     = ST_SCAN_RD;
				end else begin
					res_valid  = 1'b1;
					res.kind   = KIND_RESEND;
					res.handle = handle_rd;
					res.count  = occ_q;
					if (res_ready) begin
						// restamp the entry as it goes out
						stamp_we    = 1'b1;
						waddr       = scan_ptr_q;
						stamp_wdata = cmd_q.now;
						scan_ptr_d  = next_slot(scan_ptr_q);
						scan_left_d = scan_left_q - 1'b1;
						state_d     = ST_SCAN_RD;
					end
				end
			end
			ST_STAT_RD: begin
				re      = 1'b1;
				state_d = ST_STAT_OUT;
			end
			ST_STAT_OUT: begin
				res_valid    = 1'b1;
				res.kind     = KIND_STATUS;
				res.is_empty = (occ_q == '0);
				res.handle   = (occ_q == '0) ? '0 : handle_rd;
				res.count    = occ_q;
				res.overflow = ovf_q;
				res.last     = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		scan_ptr_q  <= scan_ptr_d;
		scan_left_q <= scan_left_d;
		ovf_q       <= ovf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
		end
	end

endmodule

// ----- hdl/rqca_outq.sv -----
// two-entry result queue between the back end and the result ports
module rqca_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	input  rqca_pkg::result_t  res,
	output logic               res_ready,
	output logic               empty,
	input  logic               pop,
	output rqca_pkg::result_t  head
);
	import rqca_pkg::*;

	result_t    slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign res_ready = (cnt_q != 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign head      = slot_q[rd_q];
	assign do_push   = res_valid && res_ready;
	assign do_pop    = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ----- hdl/retransmit_queue_cumulative_ack.sv -----
// top level of the retransmit queue with cumulative acknowledgement
// enqueue, dequeue or no-op: a read state, then an output state that offers the status beat
// acknowledge: reads and checks the head, dropping it while below the ack, then a status beat
// resend: the read-then-check loop visits every entry from the head, then a status beat
// throughput: one command at a time in the back end; two commands may wait in front of it
// reset: pointers, occupancy and both queues cleared, timeout_sec back to 5; memories kept
module retransmit_queue_cumulative_ack (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// command side
	input  logic                           push,
	output logic                           full,
	input  logic [rqca_pkg::MODE_W-1:0]    mode,
	input  logic [rqca_pkg::HANDLE_W-1:0]  message_handle,
	input  logic [rqca_pkg::ACK_W-1:0]     message_ack,
	input  logic [rqca_pkg::ACK_W-1:0]     ack_value,
	input  logic [rqca_pkg::TIME_W-1:0]    now_sec,
	// result side
	output logic                           empty,
	input  logic                           pop,
	output logic                           kind,
	output logic [rqca_pkg::HANDLE_W-1:0]  handle_out,
	output logic                           is_empty,
	output logic [rqca_pkg::CNT_W-1:0]     entry_count,
	output logic                           overflow,
	output logic                           last
);
	import rqca_pkg::*;

	logic [TMO_W-1:0] timeout_q;
	logic             cfg_sel;
	logic             cmd_valid;
	cmd_t             cmd;
	logic             cmd_take;
	logic             res_valid;
	result_t          res;
	logic             res_ready;
	result_t          head;

	// only one register, at word 0; the low address bits are don't-care
	assign cfg_sel = !paddr[2];
	assign pready  = 1'b1;
	assign prdata  = cfg_sel ? {{(32-TMO_W){1'b0}}, timeout_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			timeout_q <= pwdata[TMO_W-1:0];
		end
	end

	// front end decodes each beat into a command and buffers it
	rqca_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.mode           (mode),
		.message_handle (message_handle),
		.message_ack    (message_ack),
		.ack_value      (ack_value),
		.now_sec        (now_sec),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_take       (cmd_take)
	);

	// back end walks the entries and produces resend and status beats
	rqca_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take),
		.timeout_sec (timeout_q),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready)
	);

	// results wait here, up to two, so the back end need not stall at once when the consumer does
	rqca_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign kind        = head.kind;
	assign handle_out  = head.handle;
	assign is_empty    = head.is_empty;
	assign entry_count = head.count;
	assign overflow    = head.overflow;
	assign last        = head.last;

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench of the retransmit queue with cumulative acknowledgement
`timescale 1ns / 100ps

module tb_top;
	import rqca_pkg::*;

	// spare mode codes decode to no operation
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_RESEND_ALL + 3'd1;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = '1;
	// register map: timeout_sec is register 0
	localparam logic [2:0]        ADDR_TIMEOUT  = 3'd0;

	// quiet cycles after the last beat: room for a worst-case scan plus two waiting commands
	localparam int                SETTLE_CYCLES = 120;
	// slowest run: ~330 commands, up to 17 beats each, long pop stalls, full-queue scans
	localparam int unsigned       LIMIT_CYCLES  = 600000;
	localparam int                RANDOM_PER_PHASE = 75;

	// one command beat as it goes onto the input ports
	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [HANDLE_W-1:0] handle;
		logic [ACK_W-1:0]    mack;
		logic [ACK_W-1:0]    ackv;
		logic [TIME_W-1:0]   now;
	} command_t;

	// one report beat as it comes off the result ports
	typedef struct packed {
		logic                kind;
		logic [HANDLE_W-1:0] handle;
		logic                is_empty;
		logic [CNT_W-1:0]    count;
		logic                overflow;
		logic                last;
	} report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [2:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                push = 1'b0;
	logic                full;
	logic [MODE_W-1:0]   mode = '0;
	logic [HANDLE_W-1:0] message_handle = '0;
	logic [ACK_W-1:0]    message_ack = '0;
	logic [ACK_W-1:0]    ack_value = '0;
	logic [TIME_W-1:0]   now_sec = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic                kind;
	logic [HANDLE_W-1:0] handle_out;
	logic                is_empty;
	logic [CNT_W-1:0]    entry_count;
	logic                overflow;
	logic                last;

	retransmit_queue_cumulative_ack dut (.*);

	// commands waiting to be pushed, and report beats the queue still owes us
	command_t commands_to_send[$];
	report_t  due_reports[$];

	// shadow copy of the retransmit queue
	logic [HANDLE_W-1:0] held_handle[QUEUE_DEPTH];
	logic [ACK_W-1:0]    held_ack[QUEUE_DEPTH];
	logic [TIME_W-1:0]   held_stamp[QUEUE_DEPTH];
	int                  head_slot = 0;
	int                  tail_slot = 0;
	int                  held_count = 0;
	logic [TMO_W-1:0]    timeout_now = TIMEOUT_RESET;

	int          mismatches = 0;
	int unsigned cycle_count = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	bit          cmd_taken = 1'b0;

	// stimulus generator state: running wall clock and ack numbering
	logic [TIME_W-1:0] clock_sec = 32'h0000_0100;
	logic [ACK_W-1:0]  ack_cursor = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int next_slot(input int s);
		return (s == QUEUE_DEPTH - 1) ? 0 : s + 1;
	endfunction

	function automatic report_t make_report(input logic k, input logic [HANDLE_W-1:0] h,
			input logic e, input logic o, input logic l);
		report_t r;
		r.kind     = k;
		r.handle   = h;
		r.is_empty = e;
		r.count    = held_count[CNT_W-1:0];
		r.overflow = o;
		r.last     = l;
		return r;
	endfunction

	// apply one accepted command to the shadow queue and queue up the beats it owes
	task automatic run_queue_command(input command_t c);
		logic              ovf;
		logic [TIME_W-1:0] age;
		logic [HANDLE_W-1:0] popped;
		int                p;
		ovf = 1'b0;
		case (c.mode)
			MODE_ENQ: begin
				if (held_count >= QUEUE_DEPTH) begin
					// full: the entry is dropped and flagged
					ovf = 1'b1;
				end else begin
					held_handle[tail_slot] = c.handle;
					held_ack[tail_slot]    = c.mack;
					held_stamp[tail_slot]  = c.now;
					tail_slot = next_slot(tail_slot);
					held_count++;
				end
			end
			MODE_DEQ: begin
				// dequeue reports the popped handle, not the new head
				if (held_count == 0) begin
					due_reports.push_back(make_report(KIND_STATUS, '0, 1'b1, 1'b0, 1'b1));
				end else begin
					popped = held_handle[head_slot];
					head_slot = next_slot(head_slot);
					held_count--;
					due_reports.push_back(make_report(KIND_STATUS, popped, 1'b0, 1'b0, 1'b1));
				end
				return;
			end
			MODE_ACK: begin
				// drop from the head until an entry is not below the cumulative ack
				while (held_count > 0 && held_ack[head_slot] < c.ackv) begin
					head_slot = next_slot(head_slot);
					held_count--;
				end
			end
			MODE_RESEND_EXP, MODE_RESEND_ALL: begin
				p = head_slot;
				for (int i = 0; i < held_count; i++) begin
					// age wraps with the 32-bit clock
					age = c.now - held_stamp[p];
					if (c.mode == MODE_RESEND_ALL || age > {16'd0, timeout_now}) begin
						due_reports.push_back(make_report(KIND_RESEND, held_handle[p],
							1'b0, 1'b0, 1'b0));
						held_stamp[p] = c.now;
					end
					p = next_slot(p);
				end
			end
			default: begin
				// spare codes do nothing but report status
			end
		endcase
		if (held_count == 0)
			due_reports.push_back(make_report(KIND_STATUS, '0, 1'b1, ovf, 1'b1));
		else
			due_reports.push_back(make_report(KIND_STATUS, held_handle[head_slot], 1'b0,
				ovf, 1'b1));
	endtask

	task automatic note_mismatch(input string what, input report_t want, input report_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$write("%s: expected kind=%0d handle=%h empty=%0d count=%0d ovf=%0d last=%0d, ",
				what, want.kind, want.handle, want.is_empty, want.count, want.overflow,
				want.last);
			$display("got kind=%0d handle=%h empty=%0d count=%0d ovf=%0d last=%0d",
				got.kind, got.handle, got.is_empty, got.count, got.overflow, got.last);
		end
	endtask

	// driver: command beats and pop change on the falling edge
	always @(negedge clk) begin : drive
		command_t c;
		if (arst_n) begin
			if (!push || cmd_taken) begin
				if (commands_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					c = commands_to_send.pop_front();
					mode           <= c.mode;
					message_handle <= c.handle;
					message_ack    <= c.mack;
					ack_value      <= c.ackv;
					now_sec        <= c.now;
					push           <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
			pop <= ($urandom_range(99) >= rx_stall_pct);
		end
		cmd_taken = 1'b0;
	end

	// monitor: accepted command beats feed the shadow queue, result beats are checked in order
	always @(posedge clk) begin : observe
		report_t got;
		report_t want;
		if (arst_n) begin
			if (push && !full) begin
				cmd_taken = 1'b1;
				run_queue_command('{mode, message_handle, message_ack, ack_value, now_sec});
			end
			if (pop && !empty) begin
				got = '{kind, handle_out, is_empty, entry_count, overflow, last};
				if (due_reports.size() == 0) begin
					note_mismatch("unexpected beat", '0, got);
				end else begin
					want = due_reports.pop_front();
					if (want !== got)
						note_mismatch("report mismatch", want, got);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic add_cmd(input logic [MODE_W-1:0] m, input logic [HANDLE_W-1:0] h,
			input logic [ACK_W-1:0] ma, input logic [ACK_W-1:0] av,
			input logic [TIME_W-1:0] t);
		commands_to_send.push_back('{m, h, ma, av, t});
	endtask

	// sender stays paused until every owed beat has come back, then a quiet spell
	task automatic wait_quiet();
		while (commands_to_send.size() != 0 || push) @(posedge clk);
		while (due_reports.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [TMO_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_TIMEOUT;
		pwdata  <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		timeout_now = value;
	endtask

	task automatic check_timeout_reg();
		logic [31:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_TIMEOUT;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got[TMO_W-1:0] !== timeout_now) begin
			mismatches++;
			if (mismatches <= 10)
				$display("timeout_sec readback: expected %0d, got %0d", timeout_now,
					got[TMO_W-1:0]);
		end
	endtask

	// random commands in runs of sixteen that lean toward filling or draining the queue
	task automatic queue_random_commands(input int n);
		command_t c;
		int       enq_pct;
		int       pick;
		enq_pct = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 16 == 0)
				enq_pct = $urandom_range(1) ? 75 : 20;
			c.handle = HANDLE_W'($urandom);
			c.mack   = ACK_W'($urandom);
			c.ackv   = ACK_W'($urandom);
			if ($urandom_range(99) < enq_pct) begin
				c.mode = MODE_ENQ;
				// mostly rising ack numbers so the cumulative ack trims a prefix
				if ($urandom_range(9) != 0) begin
					c.mack = ack_cursor;
					ack_cursor = ack_cursor + ACK_W'($urandom_range(3));
				end
			end else begin
				pick = $urandom_range(99);
				if (pick < 25)
					c.mode = MODE_DEQ;
				else if (pick < 50)
					c.mode = MODE_ACK;
				else if (pick < 75)
					c.mode = MODE_RESEND_EXP;
				else if (pick < 93)
					c.mode = MODE_RESEND_ALL;
				else
					c.mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
				if (c.mode == MODE_ACK && $urandom_range(99) < 85)
					c.ackv = ack_cursor - ACK_W'($urandom_range(12));
			end
			c.now = clock_sec;
			commands_to_send.push_back(c);
			// clock mostly creeps, sometimes steps around the timeout, rarely jumps anywhere
			pick = $urandom_range(99);
			if (pick < 70)
				clock_sec = clock_sec + $urandom_range(3);
			else if (pick < 95)
				clock_sec = clock_sec + $urandom_range(2 * timeout_now + 2);
			else
				clock_sec = $urandom;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_timeout_reg();

		// directed: empty-queue corners and spare codes first
		add_cmd(MODE_DEQ, '1, '1, '1, '1);
		add_cmd(MODE_ACK, '0, '0, '1, '0);
		add_cmd(MODE_RESEND_ALL, '0, '0, '0, 32'h8000_0000);
		add_cmd(MODE_SPARE_LO, '1, '0, '1, '0);
		add_cmd(MODE_SPARE_HI, '0, '1, '0, '1);
		// fill to the brim with stamps just below the wrap; last entry carries the largest ack
		for (int i = 0; i < QUEUE_DEPTH; i++)
			add_cmd(MODE_ENQ, (i == 0) ? 16'hFFFF : HANDLE_W'(i * 32'h1111),
				(i == QUEUE_DEPTH - 1) ? '1 : ACK_W'(i), '0,
				32'hFFFF_FFF0 + TIME_W'(i));
		// one more is an overflow
		add_cmd(MODE_ENQ, 16'hABCD, 31'd99, '0, '0);
		// after the wrap all but the newest are older than the default timeout
		add_cmd(MODE_RESEND_EXP, '0, '0, '0, 32'd4);
		// cumulative ack stops at the entry equal to it
		add_cmd(MODE_ACK, '0, '0, 31'd8, 32'd5);
		add_cmd(MODE_DEQ, '0, '0, '0, 32'd6);
		add_cmd(MODE_RESEND_ALL, '0, '0, '0, 32'h7FFF_FFFF);
		wait_quiet();

		// no idling, zero timeout, clock about to wrap
		write_timeout('0);
		check_timeout_reg();
		@(posedge clk);
		clock_sec   = 32'hFFFF_FF80;
		ack_cursor  = ACK_W'($urandom);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		queue_random_commands(RANDOM_PER_PHASE);
		wait_quiet();

		// sender idles often, largest timeout
		write_timeout('1);
		check_timeout_reg();
		@(posedge clk);
		ack_cursor  = ACK_W'($urandom);
		tx_idle_pct = 56;
		rx_stall_pct = 0;
		queue_random_commands(RANDOM_PER_PHASE);
		wait_quiet();

		// receiver stalls often, short timeout
		write_timeout(TMO_W'($urandom_range(16, 1)));
		check_timeout_reg();
		@(posedge clk);
		ack_cursor  = ACK_W'($urandom);
		tx_idle_pct = 0;
		rx_stall_pct = 56;
		queue_random_commands(RANDOM_PER_PHASE);
		wait_quiet();

		// both sides idle a little, any timeout
		write_timeout(TMO_W'($urandom));
		check_timeout_reg();
		@(posedge clk);
		ack_cursor  = ACK_W'($urandom);
		tx_idle_pct = 11;
		rx_stall_pct = 11;
		queue_random_commands(RANDOM_PER_PHASE);
		wait_quiet();

		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
